[hw/rtl/pfx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pfx_pkg;

  // Operand stack geometry.
  localparam int STACK_DEPTH = 64;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Character codes of the operators and of the operand base.
  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_STAR  = 8'h2A;
  localparam logic [7:0] SYM_SLASH = 8'h2F;
  localparam logic [7:0] SYM_ZERO  = 8'h30;

  // Value given by a pop of an empty stack.
  localparam logic [7:0] EMPTY_VALUE = 8'hFF;

  // Operation codes of the shared arithmetic unit.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Index of each error mark.
  localparam int MARK_UNDER = 0;
  localparam int MARK_OVER  = 1;
  localparam int MARK_DIV0  = 2;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div0;
  } alu_rsp_t;

  // Returns 1 for the four operator characters.
  function automatic logic is_operator(input logic [7:0] sym);
    return (sym == SYM_PLUS) || (sym == SYM_MINUS) ||
           (sym == SYM_STAR) || (sym == SYM_SLASH);
  endfunction

  // Maps an operator character to its operation code.
  function automatic logic [1:0] op_code(input logic [7:0] sym);
    logic [1:0] code;
    case (sym)
      SYM_PLUS:  code = OP_ADD;
      SYM_MINUS: code = OP_SUB;
      SYM_STAR:  code = OP_MUL;
      default:   code = OP_DIV;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/pfx_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pfx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

`default_nettype wire

[hw/rtl/pfx_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pfx_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] value;
  logic              underflow;
  logic              overflow;
  logic              divide_by_zero;

  modport source (output valid, output value, output underflow, output overflow,
                  output divide_by_zero, input ready);
  modport sink   (input valid, input value, input underflow, input overflow,
                  input divide_by_zero, output ready);
endinterface

`default_nettype wire

[hw/rtl/pfx_alu.sv]
`timescale 1ns / 1ps
`default_nettype none

module pfx_alu
  import pfx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire alu_req_t   req,
  input  wire logic [7:0] lhs,
  input  wire logic [7:0] rhs,
  output alu_rsp_t        rsp,
  output logic      [7:0] result
);

  logic       busy;
  logic       done;
  logic       div0;
  logic [2:0] cnt;
  logic [8:0] rem;
  logic [7:0] quo;
  logic [7:0] dvs;
  logic       neg;

  logic [15:0] product;
  logic [7:0]  lhs_mag;
  logic [7:0]  rhs_mag;
  logic [8:0]  rem_sh;
  logic        fits;
  logic [8:0]  rem_new;
  logic [7:0]  quo_new;

  assign product = 16'($signed(lhs) * $signed(rhs));
  assign lhs_mag = lhs[7] ? 8'(-lhs) : lhs;
  assign rhs_mag = rhs[7] ? 8'(-rhs) : rhs;

  // One restoring division step per cycle on the magnitudes.
  assign rem_sh  = {rem[7:0], quo[7]};
  assign fits    = rem_sh >= {1'b0, dvs};
  assign rem_new = fits ? 9'(rem_sh - {1'b0, dvs}) : rem_sh;
  assign quo_new = {quo[6:0], fits};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      div0 <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        div0 <= 1'b0;
        case (req.op)
          OP_ADD: begin
            result <= 8'(lhs + rhs);
            done   <= 1'b1;
          end
          OP_SUB: begin
            result <= 8'(lhs - rhs);
            done   <= 1'b1;
          end
          OP_MUL: begin
            result <= product[7:0];
            done   <= 1'b1;
          end
          default: begin
            if (rhs == 8'd0) begin
              result <= 8'd0;
              div0   <= 1'b1;
              done   <= 1'b1;
            end else begin
              busy <= 1'b1;
              rem  <= '0;
              quo  <= lhs_mag;
              dvs  <= rhs_mag;
              neg  <= lhs[7] ^ rhs[7];
              cnt  <= 3'd7;
            end
          end
        endcase
      end else if (busy) begin
        rem <= rem_new;
        quo <= quo_new;
        cnt <= cnt - 3'd1;
        if (cnt == 3'd0) begin
          busy   <= 1'b0;
          done   <= 1'b1;
          result <= neg ? 8'(-quo_new) : quo_new;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.div0 = div0;

endmodule

`default_nettype wire

[hw/rtl/postfix_expression_evaluator_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Postfix expression evaluator.
// The request channel carries one character per transaction (symbol, last).
// The characters + - * / are operators; any other character pushes its code
// minus '0' as a signed 8-bit operand. An operator pops the right and then the
// left operand, computes in the shared arithmetic unit and pushes the 8-bit
// wrapped result. After the character marked last, the top is popped and sent
// on the result channel with the underflow, overflow and divide-by-zero marks
// gathered over the expression; stack and marks then start over.
// An operator's time is set by the registered stack reads and, for a nonzero
// divide, by the divider, which retires one quotient bit per cycle. A last
// character adds the final pop and the hand-off. The block accepts one
// transaction at a time and drops ready meanwhile. If the receiver stalls,
// a finished result waits in the output register and the next expression is
// still taken; only its own result waits for the slot.
// Reset (synchronous, active high) empties the stack and clears the marks and
// the output valid flag. Stack contents are not cleared and need no pass.

module postfix_expression_evaluator_core
  import pfx_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  pfx_in_if.sink    request,
  pfx_out_if.source result
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_POP_R = 4'd1;
  localparam logic [3:0] S_GET_R = 4'd2;
  localparam logic [3:0] S_POP_L = 4'd3;
  localparam logic [3:0] S_GET_L = 4'd4;
  localparam logic [3:0] S_EXEC  = 4'd5;
  localparam logic [3:0] S_WAIT  = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_GET_T = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0]       state;
  logic [CNT_W-1:0] count;
  logic [2:0]       marks;
  logic [7:0]       opnd_r;
  logic [7:0]       opnd_l;
  logic [1:0]       op;
  logic             last_r;
  logic             out_valid;
  logic [7:0]       out_value;
  logic [2:0]       out_marks;

  // Operand stack, one write and one registered read per cycle.
  logic [7:0] stack_mem [STACK_DEPTH];
  logic [7:0] rd_data;

  logic              accept;
  logic              empty;
  logic              full;
  logic [CNT_W-1:0]  count_m1;
  logic [ADDR_W-1:0] top_addr;
  logic              push_req;
  logic [7:0]        push_data;
  logic              wr_en;
  logic              slot_free;

  alu_req_t   alu_req;
  alu_rsp_t   alu_rsp;
  logic [7:0] alu_result;

  assign accept    = request.valid && request.ready;
  assign empty     = count == '0;
  assign full      = count == CNT_W'(STACK_DEPTH);
  assign count_m1  = count - 1'b1;
  assign top_addr  = count_m1[ADDR_W-1:0];
  assign slot_free = !out_valid || result.ready;

  // A push comes either from an operand character or from a finished operation.
  always_comb begin
    push_req  = 1'b0;
    push_data = alu_result;
    if (state == S_IDLE && accept && !is_operator(request.symbol)) begin
      push_req  = 1'b1;
      push_data = 8'(request.symbol - SYM_ZERO);
    end else if (state == S_WAIT && alu_rsp.done) begin
      push_req = 1'b1;
    end
  end

  assign wr_en = push_req && !full;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[count[ADDR_W-1:0]] <= push_data;
    end
    rd_data <= stack_mem[top_addr];
  end

  assign alu_req.start = state == S_EXEC;
  assign alu_req.op    = op;

  pfx_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .lhs    (opnd_l),
    .rhs    (opnd_r),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      marks     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      // Every push, wherever it comes from, either grows the stack or is dropped.
      if (push_req) begin
        if (full) begin
          marks[MARK_OVER] <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            last_r <= request.last;
            op     <= op_code(request.symbol);
            state  <= is_operator(request.symbol) ? S_POP_R : S_FIN;
          end
        end
        S_POP_R: begin
          if (empty) begin
            opnd_r            <= EMPTY_VALUE;
            marks[MARK_UNDER] <= 1'b1;
            state             <= S_POP_L;
          end else begin
            count <= count_m1;
            state <= S_GET_R;
          end
        end
        S_GET_R: begin
          opnd_r <= rd_data;
          state  <= S_POP_L;
        end
        S_POP_L: begin
          if (empty) begin
            opnd_l            <= EMPTY_VALUE;
            marks[MARK_UNDER] <= 1'b1;
            state             <= S_EXEC;
          end else begin
            count <= count_m1;
            state <= S_GET_L;
          end
        end
        S_GET_L: begin
          opnd_l <= rd_data;
          state  <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            if (alu_rsp.div0) begin
              marks[MARK_DIV0] <= 1'b1;
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!last_r) begin
            state <= S_IDLE;
          end else if (empty) begin
            opnd_r            <= EMPTY_VALUE;
            marks[MARK_UNDER] <= 1'b1;
            state             <= S_EMIT;
          end else begin
            count <= count_m1;
            state <= S_GET_T;
          end
        end
        S_GET_T: begin
          opnd_r <= rd_data;
          state  <= S_EMIT;
        end
        S_EMIT: begin
          // Hand the result over once the output register is free, then
          // start the next expression from an empty stack.
          if (slot_free) begin
            out_valid <= 1'b1;
            out_value <= opnd_r;
            out_marks <= marks;
            count     <= '0;
            marks     <= '0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign request.ready         = state == S_IDLE;
  assign result.valid          = out_valid;
  assign result.value          = out_value;
  assign result.underflow      = out_marks[MARK_UNDER];
  assign result.overflow       = out_marks[MARK_OVER];
  assign result.divide_by_zero = out_marks[MARK_DIV0];

  // The stack count never passes the stack depth.
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // In the cycle after a transaction is accepted the sequencer is busy.
  a_one_at_a_time : assert property (@(posedge clk) disable iff (rst)
    accept |=> !request.ready)
    else $error("request taken while busy");

  // A new result only appears from the hand-off state.
  a_result_source : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(state == S_EMIT))
    else $error("result raised outside hand-off");

  // The arithmetic unit only finishes while the sequencer waits for it.
  a_alu_done : assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> state == S_WAIT)
    else $error("arithmetic result with no waiting operation");

endmodule

`default_nettype wire
